// File: design/compass_heading_from_magnetometer_core_macros.svh
// ----------------------------------------------------------------------------
// compass heading core assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_FROM_MAGNETOMETER_CORE_MACROS_SVH
`define COMPASS_HEADING_FROM_MAGNETOMETER_CORE_MACROS_SVH

// same-cycle implication
`define CH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("compass core: same-cycle check failed");

// next-cycle implication
`define CH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("compass core: next-cycle check failed");

`endif

// File: design/compass_pkg.sv
// ----------------------------------------------------------------------------
// compass_pkg
// shared widths, constants, angle table and pipeline types of the heading core
// ----------------------------------------------------------------------------
package compass_pkg;

    localparam int PRESCALE_BITS   = 8;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int FULL_TURN       = 36000;
    localparam int HALF_TURN       = 18000;
    localparam int CFG_RESET       = 1261;

    // vector component width: 17-bit magnitude, prescale, cordic gain headroom
    localparam int XY_W  = 27;
    // angle accumulator: centidegrees with 16 fraction bits
    localparam int Z_W   = 32;
    // raw angle plus declination before wrapping
    localparam int TOT_W = 19;
    localparam int HEAD_W = 16;
    localparam int DECL_W = 16;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;   // left half plane, add half turn
        logic                   zero;  // zero vector, raw angle is 0
    } t_cordic_vec;

    // atan(2^-i) in centidegrees * 65536, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd294912000;
            1:       v = 32'sd174096719;
            2:       v = 32'sd91987925;
            3:       v = 32'sd46694507;
            4:       v = 32'sd23437865;
            5:       v = 32'sd11730358;
            6:       v = 32'sd5866610;
            7:       v = 32'sd2933484;
            8:       v = 32'sd1466764;
            9:       v = 32'sd733385;
            10:      v = 32'sd366693;
            11:      v = 32'sd183346;
            12:      v = 32'sd91673;
            13:      v = 32'sd45837;
            14:      v = 32'sd22918;
            15:      v = 32'sd11459;
            16:      v = 32'sd5730;
            17:      v = 32'sd2865;
            18:      v = 32'sd1432;
            19:      v = 32'sd716;
            20:      v = 32'sd358;
            21:      v = 32'sd179;
            22:      v = 32'sd90;
            23:      v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: design/compass_prep.sv
// ----------------------------------------------------------------------------
// compass_prep
// joins the axis bytes, folds the left half plane and prescales the vector
// ----------------------------------------------------------------------------
module compass_prep
    import compass_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_x_high,
    input  logic [7:0]  i_x_low,
    input  logic [7:0]  i_y_high,
    input  logic [7:0]  i_y_low,
    output logic        o_valid,
    output t_cordic_vec o_vec
);

    localparam int PAD_W = XY_W - 17 - PRESCALE_BITS;

    logic signed [15:0] w_x16;
    logic signed [15:0] w_y16;
    logic signed [16:0] w_x17;
    logic signed [16:0] w_y17;
    logic               r_valid;
    t_cordic_vec        r_vec;
    t_cordic_vec        n_vec;

    always_comb begin
        w_x16 = signed'({i_x_high, i_x_low});
        w_y16 = signed'({i_y_high, i_y_low});
        w_x17 = {w_x16[15], w_x16};
        w_y17 = {w_y16[15], w_y16};
        // negating both keeps the angle, offset by a half turn
        if (w_x16[15]) begin
            w_x17 = -w_x17;
            w_y17 = -w_y17;
        end
        n_vec.x    = {{PAD_W{w_x17[16]}}, w_x17, {PRESCALE_BITS{1'b0}}};
        n_vec.y    = {{PAD_W{w_y17[16]}}, w_y17, {PRESCALE_BITS{1'b0}}};
        n_vec.z    = '0;
        n_vec.neg  = w_x16[15];
        n_vec.zero = (w_x16 == 16'sd0) && (w_y16 == 16'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

// File: design/compass_stage.sv
// ----------------------------------------------------------------------------
// compass_stage
// one registered cordic vectoring iteration
// ----------------------------------------------------------------------------
module compass_stage
    import compass_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cordic_vec i_vec,
    output logic        o_valid,
    output t_cordic_vec o_vec
);

    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;
    logic                   r_valid;
    t_cordic_vec            r_vec;
    t_cordic_vec            n_vec;

    always_comb begin
        // arithmetic shift rounds toward minus infinity
        w_dx  = i_vec.y >>> IDX;
        w_dy  = i_vec.x >>> IDX;
        n_vec = i_vec;
        if (!i_vec.y[XY_W-1]) begin
            n_vec.x = i_vec.x + w_dx;
            n_vec.y = i_vec.y - w_dy;
            n_vec.z = i_vec.z + atan_entry(IDX);
        end else begin
            n_vec.x = i_vec.x - w_dx;
            n_vec.y = i_vec.y + w_dy;
            n_vec.z = i_vec.z - atan_entry(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

// File: design/compass_post.sv
// ----------------------------------------------------------------------------
// compass_post
// rounds the angle, adds half turn and declination, wraps into one turn
// ----------------------------------------------------------------------------
module compass_post
    import compass_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_cordic_vec              i_vec,
    input  logic signed [DECL_W-1:0] i_decl,
    output logic                     o_valid,
    output logic [HEAD_W-1:0]        o_heading
);

    localparam logic signed [TOT_W-1:0] C_FULL  = TOT_W'(FULL_TURN);
    localparam logic signed [TOT_W-1:0] C_HALF  = TOT_W'(HALF_TURN);
    localparam logic signed [TOT_W-1:0] C_TWICE = TOT_W'(2 * FULL_TURN);
    localparam logic signed [Z_W:0]     C_ROUND = (Z_W+1)'(1 << (ANGLE_FRAC_BITS - 1));
    localparam int                      ZR_W    = Z_W + 1 - ANGLE_FRAC_BITS;

    logic signed [Z_W:0]       w_zsum;
    logic signed [ZR_W-1:0]    w_zr;
    logic signed [TOT_W-1:0]   w_raw;
    logic signed [TOT_W-1:0]   n_total;
    logic signed [TOT_W-1:0]   r_total;
    logic                      r_tot_valid;
    logic signed [TOT_W-1:0]   w_wrap;
    logic [HEAD_W-1:0]         r_heading;
    logic                      r_valid;

    // stage a: round to whole centidegrees, add offsets
    always_comb begin
        w_zsum = {i_vec.z[Z_W-1], i_vec.z} + C_ROUND;
        w_zr   = w_zsum[Z_W:ANGLE_FRAC_BITS];
        if (i_vec.zero) begin
            w_raw = '0;
        end else if (i_vec.neg) begin
            w_raw = TOT_W'(w_zr) + C_HALF;
        end else begin
            w_raw = TOT_W'(w_zr);
        end
        n_total = w_raw + TOT_W'(i_decl);
    end

    // stage b: total stays within two turns either side
    always_comb begin
        if (r_total < -C_FULL) begin
            w_wrap = r_total + C_TWICE;
        end else if (r_total < 0) begin
            w_wrap = r_total + C_FULL;
        end else if (r_total >= C_FULL) begin
            w_wrap = r_total - C_FULL;
        end else begin
            w_wrap = r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_tot_valid <= i_valid;
            r_valid     <= r_tot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total   <= n_total;
        r_heading <= w_wrap[HEAD_W-1:0];
    end

    assign o_valid   = r_valid;
    assign o_heading = r_heading;

endmodule

// File: design/compass_heading_from_magnetometer_core.sv
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer_core
// cordic atan2 compass heading with declination offset, one sample per clock
// ----------------------------------------------------------------------------
// A sample (big-endian X and Y byte pairs) is taken on every clock where start
// is high; busy never rises, so samples may come back to back. The heading,
// in hundredths of a degree from 0 to 35999, shows on o_heading_centideg for
// one cycle with o_result_strobe high, after the sample has passed one input
// register, one register per cordic iteration, one rounding/offset register
// and one wrap register. The receiver cannot stall, so every strobe must be
// captured. A zero vector gives the declination alone. The declination register
// (signed centidegrees, reset 1261) is written over the cfg channel, which is
// always ready; write it only when no sample is in flight.
// ----------------------------------------------------------------------------
`include "compass_heading_from_magnetometer_core_macros.svh"

module compass_heading_from_magnetometer_core
    import compass_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample beat
    input  logic                     start,
    output logic                     busy,
    input  logic [7:0]               i_x_high,
    input  logic [7:0]               i_x_low,
    input  logic [7:0]               i_y_high,
    input  logic [7:0]               i_y_low,
    // declination write beat
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic signed [DECL_W-1:0] i_cfg_data,
    // result beat
    output logic                     o_result_strobe,
    output logic [HEAD_W-1:0]        o_heading_centideg
);

    // iterations past the angle table are not run
    localparam int RUN = (CORDIC_STAGES < ANGLE_TABLE_LEN) ? CORDIC_STAGES : ANGLE_TABLE_LEN;

    logic                     r_decl;
    logic signed [DECL_W-1:0] r_declination;
    logic                     w_valid [0:RUN];
    t_cordic_vec              w_vec   [0:RUN];

    // the pipeline never holds, so a sample is taken on every start
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // declination register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_declination <= DECL_W'(CFG_RESET);
            r_decl        <= 1'b0;
        end else begin
            r_decl <= i_cfg_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_declination <= i_cfg_data;
            end
        end
    end

    // byte join, half-plane fold, prescale
    compass_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_x_high (i_x_high),
        .i_x_low  (i_x_low),
        .i_y_high (i_y_high),
        .i_y_low  (i_y_low),
        .o_valid  (w_valid[0]),
        .o_vec    (w_vec[0])
    );

    // one stage per cordic iteration
    for (genvar g = 0; g < RUN; g++) begin : g_stage
        compass_stage #(
            .IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_vec   (w_vec[g]),
            .o_valid (w_valid[g+1]),
            .o_vec   (w_vec[g+1])
        );
    end

    // rounding, offsets, wrap into one turn
    compass_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid[RUN]),
        .i_vec     (w_vec[RUN]),
        .i_decl    (r_declination),
        .o_valid   (o_result_strobe),
        .o_heading (o_heading_centideg)
    );

    // heading always lands inside one turn
    `CH_ASSERT_SAME(a_heading_range, o_result_strobe, o_heading_centideg < HEAD_W'(FULL_TURN))
    // an accepted sample reaches the input register
    `CH_ASSERT_NEXT(a_prep_valid, start, w_valid[0])
    // a sample leaving the last iteration is not dropped in the back end
    `CH_ASSERT_NEXT(a_tail_valid, w_valid[RUN], ##1 o_result_strobe)
    // a declination write beat lands in the register in the next cycle
    `CH_ASSERT_SAME(a_cfg_track, r_decl, r_declination == $past(i_cfg_data))

endmodule

// File: tb/sv/compass_heading_from_magnetometer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer_core_tb
// self-checking bench: byte-pair samples in, wrapped cordic headings checked
// ----------------------------------------------------------------------------
// A queue of pending beats (samples, declination writes, drain points) is
// filled at time zero and fed to the core by a clocked driver. A clocked
// monitor computes the expected heading of every accepted sample with an
// integer cordic of its own, then checks each strobed result against the
// oldest expectation. The declination is changed only once the pipeline has
// emptied. A watchdog ends the run when nothing moves for too long.
// ----------------------------------------------------------------------------
module compass_heading_from_magnetometer_core_tb;
    import compass_pkg::*;

    localparam int STAGES      = 16;
    localparam int PIPE_DEPTH  = STAGES + 3;   // sample beat to result strobe
    localparam int STALL_LIMIT = 600;          // cycles with no beat at all
    localparam int REPORT_MAX  = 10;

    typedef enum logic [1:0] {
        BEAT_SAMPLE,
        BEAT_DECL,
        BEAT_DRAIN
    } t_beat_kind;

    // one entry of the stimulus queue
    typedef struct packed {
        t_beat_kind              kind;
        logic [15:0]             x;       // joined x bytes, big-endian
        logic [15:0]             y;       // joined y bytes, big-endian
        logic signed [DECL_W-1:0] decl;
        logic [3:0]              gap;     // idle cycles before this beat
    } t_beat;

    // one heading still owed by the core
    typedef struct packed {
        logic [15:0]       x;
        logic [15:0]       y;
        logic [HEAD_W-1:0] heading;
    } t_heading_exp;

    // atan(2^-i) in centidegrees with 16 fraction bits
    longint atan_cdeg [0:23] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45
    };

    // dut signals; the driven ones are known from time zero
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     start          = 1'b0;
    logic                     busy;
    logic [7:0]               i_x_high       = '0;
    logic [7:0]               i_x_low        = '0;
    logic [7:0]               i_y_high       = '0;
    logic [7:0]               i_y_low        = '0;
    logic                     i_cfg_valid    = 1'b0;
    logic                     o_cfg_ready;
    logic signed [DECL_W-1:0] i_cfg_data     = '0;
    logic                     o_result_strobe;
    logic [HEAD_W-1:0]        o_heading_centideg;

    t_beat        pending_beats [$];
    t_heading_exp owed_headings [$];

    logic signed [DECL_W-1:0] decl_now = DECL_W'(CFG_RESET);  // bench copy of the register
    bit          pipe_empty = 1'b1;    // snapshot of owed_headings taken at falling edge
    bit          allow_gaps = 1'b1;
    bit          gap_taken  = 1'b0;
    int unsigned idle_left  = 0;
    int unsigned stall_cnt  = 0;
    int unsigned mismatches = 0;

    compass_heading_from_magnetometer_core #(
        .CORDIC_STAGES (STAGES)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_x_high           (i_x_high),
        .i_x_low            (i_x_low),
        .i_y_high           (i_y_high),
        .i_y_low            (i_y_low),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_result_strobe    (o_result_strobe),
        .o_heading_centideg (o_heading_centideg)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // heading predictor: vectoring cordic on the joined axes, then offset and
    // wrap into one full turn
    // ------------------------------------------------------------------------
    function automatic logic [HEAD_W-1:0] predict_heading(input logic [15:0] xw,
                                                          input logic [15:0] yw,
                                                          input logic signed [DECL_W-1:0] decl);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint base;
        longint total;
        x    = longint'($signed(xw));
        y    = longint'($signed(yw));
        z    = 0;
        base = 0;
        // a zero vector keeps a raw angle of zero
        if (x != 0 || y != 0) begin
            // left half plane: rotate by a half turn first
            if (x < 0) begin
                x    = -x;
                y    = -y;
                base = HALF_TURN;
            end
            x = x * (64'sd1 <<< PRESCALE_BITS);
            y = y * (64'sd1 <<< PRESCALE_BITS);
            for (int i = 0; i < STAGES && i < ANGLE_TABLE_LEN; i++) begin
                // arithmetic shifts floor toward minus infinity
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_cdeg[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_cdeg[i];
                end
            end
            // round to whole centidegrees
            z = ((z + (64'sd1 <<< (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS) + base;
        end
        total = (z + longint'(decl)) % FULL_TURN;
        if (total < 0)
            total = total + FULL_TURN;
        return total[HEAD_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // stimulus queue helpers
    // ------------------------------------------------------------------------
    function automatic logic [3:0] pick_gap();
        if (allow_gaps && $urandom_range(0, 4) == 0)
            return 4'($urandom_range(1, 13));
        return '0;
    endfunction

    task automatic queue_beat(input t_beat_kind kind, input logic [15:0] x,
                              input logic [15:0] y, input logic signed [DECL_W-1:0] decl);
        t_beat b;
        b.kind = kind;
        b.x    = x;
        b.y    = y;
        b.decl = decl;
        b.gap  = pick_gap();
        pending_beats.push_back(b);
    endtask

    task automatic queue_sample(input logic [15:0] x, input logic [15:0] y);
        queue_beat(BEAT_SAMPLE, x, y, '0);
    endtask

    // axis extremes, quadrant boundaries, the zero vector and the left half plane
    task automatic queue_directed();
        queue_sample(16'h0000, 16'h0000);   // zero vector, declination alone
        queue_sample(16'h7FFF, 16'h0000);
        queue_sample(16'h8000, 16'h0000);   // most negative x, straight back
        queue_sample(16'hFFFF, 16'h0000);   // x = -1 on the axis
        queue_sample(16'h0001, 16'h0000);
        queue_sample(16'h0000, 16'h7FFF);
        queue_sample(16'h0000, 16'h8000);
        queue_sample(16'h0000, 16'h0001);
        queue_sample(16'h0000, 16'hFFFF);
        queue_sample(16'h7FFF, 16'h7FFF);
        queue_sample(16'h8000, 16'h8000);
        queue_sample(16'h7FFF, 16'h8000);
        queue_sample(16'h8000, 16'h7FFF);
        queue_sample(16'hFFFF, 16'hFFFF);
        queue_sample(16'h8000, 16'h0001);   // just above the negative x axis
        queue_sample(16'h8000, 16'hFFFF);   // just below it
        queue_sample(16'h0001, 16'hFFFF);
        queue_sample(16'hFFFF, 16'h7FFF);
        queue_sample(16'h00FF, 16'hFF00);   // byte halves with opposite signs
        queue_sample(16'hFF00, 16'h00FF);
        queue_sample(16'h0080, 16'h8080);   // low byte msb must not sign-extend
    endtask

    // random sample, weighted toward the awkward corners of the plane
    task automatic queue_random(input int unsigned count);
        shortint sx;
        shortint sy;
        shortint corner [5];
        corner = '{-32768, -1, 0, 1, 32767};
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    sx = shortint'($urandom);
                    sy = shortint'($urandom);
                end
                5: begin
                    sx = shortint'($urandom_range(0, 16)) - 16'sd8;
                    sy = shortint'($urandom_range(0, 16)) - 16'sd8;
                end
                6: begin
                    sx = shortint'($urandom);
                    sy = 0;
                    if ($urandom_range(0, 1) == 1) begin
                        sy = sx;
                        sx = 0;
                    end
                end
                7: begin
                    sx = corner[$urandom_range(0, 4)];
                    sy = corner[$urandom_range(0, 4)];
                end
                8: begin
                    sx = shortint'($urandom);
                    sy = ($urandom_range(0, 1) == 1) ? sx : -sx;
                end
                default: begin
                    sx = -shortint'($urandom_range(1, 32767));
                    sy = shortint'($urandom_range(0, 6)) - 16'sd3;
                end
            endcase
            queue_sample(sx, sy);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus plan and end of run
    // ------------------------------------------------------------------------
    initial begin
        // reset declination first
        queue_directed();
        // positive extreme: a straight-back heading wraps to exactly zero
        queue_beat(BEAT_DECL, '0, '0, 16'sd18000);
        queue_directed();
        queue_beat(BEAT_DECL, '0, '0, -16'sd18000);
        queue_directed();

        queue_beat(BEAT_DECL, '0, '0, -16'sd1);
        queue_random(50);
        queue_beat(BEAT_DRAIN, '0, '0, '0);   // sender holds until the pipe is empty
        queue_random(50);

        allow_gaps = 1'b0;                    // a stretch with no idling
        queue_beat(BEAT_DECL, '0, '0, 16'sd0);
        queue_random(100);
        allow_gaps = 1'b1;

        queue_beat(BEAT_DECL, '0, '0, 16'sd18000);
        queue_random(100);
        queue_beat(BEAT_DECL, '0, '0, -16'sd18000);
        queue_random(80);
        queue_beat(BEAT_DECL, '0, '0, DECL_W'(int'($urandom_range(0, 36000)) - 18000));
        queue_random(60);
        queue_beat(BEAT_DRAIN, '0, '0, '0);
        queue_random(40);

        // final stretch runs flat out
        allow_gaps = 1'b0;
        queue_beat(BEAT_DECL, '0, '0, DECL_W'(int'($urandom_range(0, 36000)) - 18000));
        queue_random(120);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(pending_beats.size() == 0 && !start && !i_cfg_valid && pipe_empty))
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);

        if (owed_headings.size() != 0) begin
            $display("%0d heading(s) never came back", owed_headings.size());
            mismatches = mismatches + owed_headings.size();
        end
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // sampled away from the rising edge so the driver never races the monitor
    always @(negedge i_clk) begin
        pipe_empty = (owed_headings.size() == 0);
    end

    // ------------------------------------------------------------------------
    // driver: sample beats go straight out, declination writes and drain
    // points wait for an empty pipe; next values are settled before the one
    // nonblocking update of each handshake signal
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        logic  nxt_start;
        logic  nxt_cfg;
        t_beat head;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            // a beat stays up until it is taken
            nxt_start = start && busy;
            nxt_cfg   = i_cfg_valid && !o_cfg_ready;
            if (!nxt_start && !nxt_cfg) begin
                if (idle_left != 0) begin
                    idle_left = idle_left - 1;
                end else if (pending_beats.size() != 0) begin
                    head = pending_beats[0];
                    if (head.gap != 0 && !gap_taken) begin
                        idle_left = head.gap - 1;
                        gap_taken = 1'b1;
                    end else begin
                        case (head.kind)
                            BEAT_SAMPLE: begin
                                nxt_start = 1'b1;
                                i_x_high  <= head.x[15:8];
                                i_x_low   <= head.x[7:0];
                                i_y_high  <= head.y[15:8];
                                i_y_low   <= head.y[7:0];
                                void'(pending_beats.pop_front());
                                gap_taken = 1'b0;
                            end
                            BEAT_DECL: begin
                                if (pipe_empty && !start) begin
                                    nxt_cfg    = 1'b1;
                                    i_cfg_data <= head.decl;
                                    void'(pending_beats.pop_front());
                                    gap_taken = 1'b0;
                                end
                            end
                            default: begin
                                if (pipe_empty && !start) begin
                                    void'(pending_beats.pop_front());
                                    gap_taken = 1'b0;
                                end
                            end
                        endcase
                    end
                end
            end
            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on every accepted sample, check every strobed heading,
    // and watch for a stuck pipe
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_proc
        t_heading_exp want;
        bit           moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                decl_now = i_cfg_data;
                moved    = 1'b1;
            end
            if (start && !busy) begin
                want.x       = {i_x_high, i_x_low};
                want.y       = {i_y_high, i_y_low};
                want.heading = predict_heading(want.x, want.y, decl_now);
                owed_headings.push_back(want);
                moved = 1'b1;
            end
            if (o_result_strobe) begin
                moved = 1'b1;
                if (owed_headings.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected heading beat: %0d", o_heading_centideg);
                    mismatches = mismatches + 1;
                end else begin
                    want = owed_headings.pop_front();
                    if (o_heading_centideg !== want.heading) begin
                        if (mismatches < REPORT_MAX)
                            $display("heading x=%0d y=%0d: expected %0d, got %0d",
                                     $signed(want.x), $signed(want.y),
                                     want.heading, o_heading_centideg);
                        mismatches = mismatches + 1;
                    end
                end
            end
            stall_cnt = moved ? 0 : stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("no beat for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule
